### rtl/pcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants for the pixel channel-count converter.
// ----------------------------------------------------------------------------
package pcc_pkg;

	localparam int PIX_W  = 8;
	localparam int CH_W   = 3;
	localparam int IDX_W  = 2;
	localparam int PROD_W = 16;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [CH_W-1:0]   chan_t;
	typedef logic [IDX_W-1:0]  cfg_idx_t;
	typedef logic [PROD_W-1:0] prod_t;

	localparam chan_t CH_GRAY  = 3'd1;
	localparam chan_t CH_GRAYA = 3'd2;
	localparam chan_t CH_RGB   = 3'd3;
	localparam chan_t CH_RGBA  = 3'd4;

	localparam cfg_idx_t REG_SOURCE_CHANNELS = 2'd0;
	localparam cfg_idx_t REG_TARGET_CHANNELS = 2'd1;

	localparam chan_t SOURCE_RESET = CH_RGB;
	localparam chan_t TARGET_RESET = CH_GRAY;

	localparam prod_t LUMA_WR = 16'd77;
	localparam prod_t LUMA_WG = 16'd150;
	localparam prod_t LUMA_WB = 16'd29;
	localparam int    LUMA_SHIFT = 8;

	localparam pix_t ALPHA_OPAQUE = 8'd255;

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
	} pcc_load_t;

endpackage

### rtl/pcc_luma.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_luma
// Two-stage luma datapath: weighted products, then sum and scale.
// ----------------------------------------------------------------------------
module pcc_luma (
	input  logic               clk,
	input  pcc_pkg::pcc_load_t ld,
	input  pcc_pkg::pix_t      r,
	input  pcc_pkg::pix_t      g,
	input  pcc_pkg::pix_t      b,
	output pcc_pkg::pix_t      gray
);
	import pcc_pkg::*;

	prod_t pr_s1;
	prod_t pg_s1;
	prod_t pb_s1;
	prod_t sum_s2;

	always_ff @(posedge clk) begin
		if (ld.ld_s1) begin
			pr_s1 <= LUMA_WR * prod_t'(r);
			pg_s1 <= LUMA_WG * prod_t'(g);
			pb_s1 <= LUMA_WB * prod_t'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld_s2) begin
			sum_s2 <= pr_s1 + pg_s1 + pb_s1;
		end
	end

	assign gray = sum_s2[LUMA_SHIFT +: PIX_W];

endmodule

### rtl/pixel_channel_count_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_channel_count_converter_top
// Converts one 8-bit pixel between gray, gray+alpha, RGB and RGBA.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   in      | in_valid / in_ready  | in_c0..in_c3, in_last
//   out     | out_valid / out_ready| out_c0..out_c3, out_last
//   cfg     | cfg_we               | cfg_index, cfg_data
//
// Three register stages: input and luma products, luma sum, output select.
// One pixel per cycle while the output is not stalled.
// A stall at the output holds the full stages back to the first empty one; an empty stage keeps filling.
// Reset clears the stage valid bits and loads source RGB, target gray.
// ----------------------------------------------------------------------------
module pixel_channel_count_converter_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  pcc_pkg::cfg_idx_t cfg_index,
	input  pcc_pkg::chan_t    cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  pcc_pkg::pix_t     in_c0,
	input  pcc_pkg::pix_t     in_c1,
	input  pcc_pkg::pix_t     in_c2,
	input  pcc_pkg::pix_t     in_c3,
	input  logic              in_last,
	output logic              out_valid,
	input  logic              out_ready,
	output pcc_pkg::pix_t     out_c0,
	output pcc_pkg::pix_t     out_c1,
	output pcc_pkg::pix_t     out_c2,
	output pcc_pkg::pix_t     out_c3,
	output logic              out_last
);
	import pcc_pkg::*;

	chan_t src_q;
	chan_t tgt_q;

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;
	pcc_load_t ld;

	pix_t c0_s1, c1_s1, c2_s1, c3_s1;
	logic last_s1;
	pix_t c0_s2, c1_s2, c2_s2, c3_s2;
	logic last_s2;
	pix_t c0_s3, c1_s3, c2_s3, c3_s3;
	logic last_s3;

	pix_t luma;
	pix_t gray, r, g, b, alpha;
	pix_t res0, res1, res2, res3;
	logic cfg_ok;

	// configuration
	assign cfg_ok = (cfg_data inside {[CH_GRAY:CH_RGBA]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= SOURCE_RESET;
			tgt_q <= TARGET_RESET;
		end else if (cfg_we && cfg_ok) begin
			case (cfg_index)
				REG_SOURCE_CHANNELS: src_q <= cfg_data;
				REG_TARGET_CHANNELS: tgt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign ld.ld_s1 = rdy1 && in_valid;
	assign ld.ld_s2 = rdy2 && v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld_s1) begin
			c0_s1   <= in_c0;
			c1_s1   <= in_c1;
			c2_s1   <= in_c2;
			c3_s1   <= in_c3;
			last_s1 <= in_last;
		end
		if (ld.ld_s2) begin
			c0_s2   <= c0_s1;
			c1_s2   <= c1_s1;
			c2_s2   <= c2_s1;
			c3_s2   <= c3_s1;
			last_s2 <= last_s1;
		end
	end

	pcc_luma u_luma (
		.clk  (clk),
		.ld   (ld),
		.r    (in_c0),
		.g    (in_c1),
		.b    (in_c2),
		.gray (luma)
	);

	// decode source, then build target
	always_comb begin
		case (src_q)
			CH_GRAY: begin
				gray = c0_s2; r = c0_s2; g = c0_s2; b = c0_s2;
				alpha = ALPHA_OPAQUE;
			end
			CH_GRAYA: begin
				gray = c0_s2; r = c0_s2; g = c0_s2; b = c0_s2;
				alpha = c1_s2;
			end
			CH_RGBA: begin
				gray = luma; r = c0_s2; g = c1_s2; b = c2_s2;
				alpha = c3_s2;
			end
			default: begin
				gray = luma; r = c0_s2; g = c1_s2; b = c2_s2;
				alpha = ALPHA_OPAQUE;
			end
		endcase

		res0 = '0; res1 = '0; res2 = '0; res3 = '0;
		if (tgt_q == src_q) begin
			res0 = c0_s2; res1 = c1_s2; res2 = c2_s2; res3 = c3_s2;
		end else begin
			case (tgt_q)
				CH_GRAY: res0 = gray;
				CH_GRAYA: begin
					res0 = gray; res1 = alpha;
				end
				CH_RGB: begin
					res0 = r; res1 = g; res2 = b;
				end
				default: begin
					res0 = r; res1 = g; res2 = b; res3 = alpha;
				end
			endcase
		end

		// drop channels beyond the target count
		if (tgt_q < CH_GRAYA) res1 = '0;
		if (tgt_q < CH_RGB)   res2 = '0;
		if (tgt_q < CH_RGBA)  res3 = '0;
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			c0_s3   <= res0;
			c1_s3   <= res1;
			c2_s3   <= res2;
			c3_s3   <= res3;
			last_s3 <= last_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_c0    = c0_s3;
	assign out_c1    = c1_s3;
	assign out_c2    = c2_s3;
	assign out_c3    = c3_s3;
	assign out_last  = last_s3;

	a_cfg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(src_q >= CH_GRAY) && (src_q <= CH_RGBA) && (tgt_q >= CH_GRAY) && (tgt_q <= CH_RGBA))
		else $error("channel count register out of range");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && !out_ready) |-> !in_ready)
		else $error("input taken while pipeline is full and stalled");

	a_gray_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && tgt_q == CH_GRAY) |-> (out_c1 == '0 && out_c2 == '0 && out_c3 == '0))
		else $error("unused result channels not zero for gray target");

	a_s3_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && rdy3) |=> v_s3)
		else $error("stage three lost a transfer");

endmodule

### bench/tb_pixel_channel_count_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_channel_count_converter_top
// Self-checking bench for the pixel channel-count converter.
//
// A queue of pixels feeds a valid/ready driver, and every accepted transfer
// is converted by a local model of the format rules into an expected pixel.
// A monitor compares each output transfer field by field in order. Each
// pairing of source and target channel counts runs under three idle
// patterns. Rejected register writes and one long output stall are included.
// ----------------------------------------------------------------------------
module tb_pixel_channel_count_converter_top;

	import pcc_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 5;
	localparam int PHASE_PIXELS   = 40;
	localparam int SETTLE_CYCLES  = 8;
	localparam int LONG_STALL     = 60;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int LUMA_RED       = 77;
	localparam int LUMA_GREEN     = 150;
	localparam int LUMA_BLUE      = 29;

	typedef struct packed {
		pix_t c0;
		pix_t c1;
		pix_t c2;
		pix_t c3;
		logic last;
	} pixel_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_we = 1'b0;
	cfg_idx_t cfg_index = REG_SOURCE_CHANNELS;
	chan_t    cfg_data = CH_GRAY;
	logic     in_valid = 1'b0;
	logic     in_ready;
	pix_t     in_c0 = '0;
	pix_t     in_c1 = '0;
	pix_t     in_c2 = '0;
	pix_t     in_c3 = '0;
	logic     in_last = 1'b0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	pix_t     out_c0;
	pix_t     out_c1;
	pix_t     out_c2;
	pix_t     out_c3;
	logic     out_last;

	pixel_t pending_pixels[$];
	pixel_t expected_pixels[$];
	chan_t  src_mode = CH_RGB;
	chan_t  dst_mode = CH_GRAY;
	int     sender_idle_pct = 7;
	int     receiver_idle_pct = 47;
	logic   long_stall_go = 1'b0;
	logic   long_stall_taken = 1'b0;
	int     long_stall_left = 0;
	int     error_count = 0;
	int     cycle_count = 0;

	pixel_channel_count_converter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_c0    (in_c0),
		.in_c1    (in_c1),
		.in_c2    (in_c2),
		.in_c3    (in_c3),
		.in_last  (in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_c0   (out_c0),
		.out_c1   (out_c1),
		.out_c2   (out_c2),
		.out_c3   (out_c3),
		.out_last (out_last)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	function automatic pixel_t convert_pixel(pixel_t px, chan_t src, chan_t dst);
		pixel_t      res;
		pix_t        red, green, blue, gray, alpha;
		int unsigned weighted;
		weighted = LUMA_RED * px.c0 + LUMA_GREEN * px.c1 + LUMA_BLUE * px.c2;
		case (src)
			CH_GRAY: begin
				red = px.c0; green = px.c0; blue = px.c0; gray = px.c0;
				alpha = 8'hFF;
			end
			CH_GRAYA: begin
				red = px.c0; green = px.c0; blue = px.c0; gray = px.c0;
				alpha = px.c1;
			end
			CH_RGBA: begin
				red = px.c0; green = px.c1; blue = px.c2; gray = pix_t'(weighted >> 8);
				alpha = px.c3;
			end
			default: begin
				red = px.c0; green = px.c1; blue = px.c2; gray = pix_t'(weighted >> 8);
				alpha = 8'hFF;
			end
		endcase
		res = '0;
		res.last = px.last;
		if (src == dst) begin
			res = px;
		end else begin
			case (dst)
				CH_GRAY: res.c0 = gray;
				CH_GRAYA: begin
					res.c0 = gray; res.c1 = alpha;
				end
				CH_RGB: begin
					res.c0 = red; res.c1 = green; res.c2 = blue;
				end
				default: begin
					res.c0 = red; res.c1 = green; res.c2 = blue; res.c3 = alpha;
				end
			endcase
		end
		if (dst < CH_GRAYA)
			res.c1 = '0;
		if (dst < CH_RGB)
			res.c2 = '0;
		if (dst < CH_RGBA)
			res.c3 = '0;
		return res;
	endfunction

	function automatic pix_t rand_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return pix_t'($urandom_range(255));
		endcase
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t px;
		px.c0 = rand_byte();
		px.c1 = rand_byte();
		px.c2 = rand_byte();
		px.c3 = rand_byte();
		px.last = ($urandom_range(15) == 0);
		return px;
	endfunction

	function automatic pixel_t make_pixel(pix_t a, pix_t b, pix_t c, pix_t d, logic l);
		pixel_t px;
		px.c0 = a; px.c1 = b; px.c2 = c; px.c3 = d; px.last = l;
		return px;
	endfunction

	task automatic check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			error_count++;
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
		end
	endtask

	// mirror of the configuration registers; out-of-range data and unknown indexes drop
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_mode <= CH_RGB;
			dst_mode <= CH_GRAY;
		end else if (cfg_we && cfg_data >= CH_GRAY && cfg_data <= CH_RGBA) begin
			if (cfg_index == REG_SOURCE_CHANNELS)
				src_mode <= cfg_data;
			else if (cfg_index == REG_TARGET_CHANNELS)
				dst_mode <= cfg_data;
		end
	end

	// input driver
	always @(posedge clk) begin
		pixel_t px;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_pixels.push_back(convert_pixel(
					make_pixel(in_c0, in_c1, in_c2, in_c3, in_last), src_mode, dst_mode));
			if (!in_valid || in_ready) begin
				if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					px = pending_pixels.pop_front();
					in_c0 <= px.c0;
					in_c1 <= px.c1;
					in_c2 <= px.c2;
					in_c3 <= px.c3;
					in_last <= px.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver stall counter
	always @(posedge clk) begin
		if (arst_n) begin
			if (long_stall_left > 0) begin
				long_stall_left <= long_stall_left - 1;
			end else if (long_stall_go && !long_stall_taken) begin
				long_stall_taken <= 1'b1;
				long_stall_left <= LONG_STALL;
			end
		end
	end

	// output monitor and ready generation
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					error_count++;
					$display("%0t: transfer expected none actual %h %h %h %h %b", $time,
						out_c0, out_c1, out_c2, out_c3, out_last);
				end else begin
					want = expected_pixels.pop_front();
					check_field("out_c0", want.c0, out_c0);
					check_field("out_c1", want.c1, out_c1);
					check_field("out_c2", want.c2, out_c2);
					check_field("out_c3", want.c3, out_c3);
					check_field("out_last", want.last, out_last);
				end
			end
			if (long_stall_left > 0 || (long_stall_go && !long_stall_taken))
				out_ready <= 1'b0;
			else
				out_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(cfg_idx_t idx, chan_t val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_junk();
		case ($urandom_range(3))
			0: write_reg(REG_SOURCE_CHANNELS, chan_t'($urandom_range(5, 8) & 7));
			1: write_reg(REG_TARGET_CHANNELS, chan_t'($urandom_range(5, 8) & 7));
			2: write_reg(cfg_idx_t'($urandom_range(2, 3)), chan_t'($urandom_range(7)));
			default: ;
		endcase
	endtask

	initial begin
		int src, dst, mode;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset setting: rgb to gray
		pending_pixels.push_back(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		pending_pixels.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
		pending_pixels.push_back(make_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 1'b0));
		pending_pixels.push_back(make_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0));
		pending_pixels.push_back(make_pixel(8'h00, 8'h00, 8'hFF, 8'h00, 1'b0));
		pending_pixels.push_back(make_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0));
		pending_pixels.push_back(make_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1));
		wait_drained();

		// rejected writes leave the setting alone
		write_reg(REG_SOURCE_CHANNELS, 3'd0);
		write_reg(REG_TARGET_CHANNELS, 3'd7);
		write_reg(REG_SOURCE_CHANNELS, 3'd5);
		write_reg(REG_TARGET_CHANNELS, 3'd6);
		write_reg(cfg_idx_t'(2), CH_RGBA);
		write_reg(cfg_idx_t'(3), CH_GRAYA);
		@(negedge clk);
		pending_pixels.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0));
		pending_pixels.push_back(make_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b1));
		wait_drained();

		// gray to rgba: replicate, opaque alpha
		write_reg(REG_SOURCE_CHANNELS, CH_GRAY);
		write_reg(REG_TARGET_CHANNELS, CH_RGBA);
		@(negedge clk);
		pending_pixels.push_back(make_pixel(8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0));
		pending_pixels.push_back(make_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 1'b1));
		wait_drained();

		// rgba to gray+alpha: alpha carried
		write_reg(REG_SOURCE_CHANNELS, CH_RGBA);
		write_reg(REG_TARGET_CHANNELS, CH_GRAYA);
		@(negedge clk);
		pending_pixels.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0));
		pending_pixels.push_back(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1));
		wait_drained();

		for (mode = 0; mode < 3; mode++) begin
			for (src = CH_GRAY; src <= CH_RGBA; src++) begin
				for (dst = CH_GRAY; dst <= CH_RGBA; dst++) begin
					if ($urandom_range(1)) begin
						write_reg(REG_SOURCE_CHANNELS, chan_t'(src));
						write_reg(REG_TARGET_CHANNELS, chan_t'(dst));
					end else begin
						write_reg(REG_TARGET_CHANNELS, chan_t'(dst));
						write_reg(REG_SOURCE_CHANNELS, chan_t'(src));
					end
					write_junk();
					@(negedge clk);
					case (mode)
						0: begin
							sender_idle_pct = 7; receiver_idle_pct = 47;
						end
						1: begin
							sender_idle_pct = 47; receiver_idle_pct = 7;
						end
						default: begin
							sender_idle_pct = 0; receiver_idle_pct = 0;
							long_stall_go = 1'b1;
						end
					endcase
					repeat (PHASE_PIXELS) pending_pixels.push_back(rand_pixel());
					wait_drained();
				end
			end
		end

		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
